// File: sv/smpq_pkg.sv
`default_nettype none
package smpq_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_OUT_W = 5;

	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
		logic signed [DATA_W-1:0] value;
	} smpq_ctl_t;

endpackage
`default_nettype wire

// File: sv/smpq_cell.sv
`default_nettype none
module smpq_cell
	import smpq_pkg::*;
(
	input wire logic clk,
	input wire smpq_ctl_t ctl,
	input wire logic occupied,
	input wire logic left_ins,
	input wire logic signed [DATA_W-1:0] left_entry,
	input wire logic signed [DATA_W-1:0] right_entry,
	output logic ins,
	output logic signed [DATA_W-1:0] entry
);

	logic signed [DATA_W-1:0] entry_q;
	logic signed [DATA_W-1:0] entry_d;

	assign entry = entry_q;

	// at or past the insertion point of the pushed value
	assign ins = !occupied || !(entry_q < ctl.value);

	always_comb begin
		entry_d = entry_q;
		if (ctl.push) begin
			if (ins) begin
				entry_d = left_ins ? left_entry : ctl.value;
			end
		end else if (ctl.pop) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule
`default_nettype wire

// File: sv/sorted_min_priority_queue.sv
// latency: the result of a transaction is presented the cycle after it is accepted
// throughput: one transaction per cycle unless m_tready stalls the output, each
// command a single pass through the row of cells, shifting or loading in parallel
// reset: entry count and output valid clear asynchronously, cell contents stay
// undefined until written and are never read before that
`default_nettype none
module sorted_min_priority_queue
	import smpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [DATA_W-1:0] s_tdata, // value
	input wire logic [CMD_W-1:0] s_tuser, // command
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [39:0] m_tdata // smallest, is_empty, entry_count, status
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] status_d;
	logic m_tvalid_q;
	logic s_accept;
	logic full;
	logic empty;
	smpq_ctl_t ctl;
	logic ins_w [QUEUE_DEPTH];
	logic signed [DATA_W-1:0] entry_w [QUEUE_DEPTH];
	logic [CW+COUNT_OUT_W-1:0] count_ext;
	logic signed [DATA_W-1:0] smallest;

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign ctl.push = s_accept && (s_tuser == CMD_PUSH) && !full;
	assign ctl.pop = s_accept && (s_tuser == CMD_POP) && !empty;
	assign ctl.value = $signed(s_tdata);

	always_comb begin
		count_d = count_q;
		status_d = ST_OK;
		case (s_tuser)
			CMD_PUSH: begin
				if (full) status_d = ST_FULL;
				else count_d = count_q + CW'(1);
			end
			CMD_POP: begin
				if (empty) status_d = ST_EMPTY;
				else count_d = count_q - CW'(1);
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				count_q <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			status_q <= status_d;
		end
	end

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic left_ins;
			logic signed [DATA_W-1:0] left_entry;
			logic signed [DATA_W-1:0] right_entry;

			if (i == 0) begin : g_head
				assign left_ins = 1'b0;
				assign left_entry = ctl.value;
			end else begin : g_body
				assign left_ins = ins_w[i-1];
				assign left_entry = entry_w[i-1];
			end

			if (i == QUEUE_DEPTH - 1) begin : g_tail
				assign right_entry = entry_w[i];
			end else begin : g_next
				assign right_entry = entry_w[i+1];
			end

			smpq_cell u_cell (
				.clk(clk),
				.ctl(ctl),
				.occupied(count_q > CW'(i)),
				.left_ins(left_ins),
				.left_entry(left_entry),
				.right_entry(right_entry),
				.ins(ins_w[i]),
				.entry(entry_w[i])
			);
		end
	endgenerate

	// state only moves on an accepted transaction, so a stalled result holds
	assign smallest = empty ? '0 : entry_w[0];
	assign count_ext = {{COUNT_OUT_W{1'b0}}, count_q};
	assign m_tdata = {status_q, count_ext[COUNT_OUT_W-1:0], empty, smallest};

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not add an entry");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_tuser == CMD_POP) && empty |=> status_q == ST_EMPTY && m_tvalid)
		else $error("pop on empty queue not flagged");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> entry_w[0] <= entry_w[1])
		else $error("head entries out of order");
`endif

endmodule
`default_nettype wire
